// ===== hdl/mstc_pkg.sv =====
package mstc_pkg;

	// Q16.16 one.
	localparam logic [16:0] Q_ONE = 17'h10000;

	// Shared unit operations.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// Quotient bits for the slowdown factor and for the stored acceleration.
	localparam logic [4:0] DIV_F_BITS = 5'd16;
	localparam logic [4:0] DIV_A_BITS = 5'd31;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MAX_TORQUE     = 2'd0;
	localparam logic [1:0] REG_INERTIA_GAIN   = 2'd1;
	localparam logic [1:0] REG_RESIST_DAMPING = 2'd2;
	localparam logic [1:0] REG_RAMP_STEP      = 2'd3;

	// Request to the shared arithmetic unit. For a multiply, opa is the magnitude of
	// the signed operand, neg its sign and opb the unsigned factor. For a divide, opa
	// holds the initial remainder, opb the divisor and opc the remaining dividend bits.
	typedef struct packed {
		logic        start;
		logic        op;
		logic        neg;
		logic [32:0] opa;
		logic [31:0] opb;
		logic [30:0] opc;
		logic [4:0]  iters;
	} mstc_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} mstc_rsp_t;

endpackage

// ===== hdl/mstc_arith.sv =====
module mstc_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  mstc_pkg::mstc_req_t req,
	output mstc_pkg::mstc_rsp_t rsp
);
	import mstc_pkg::*;

	localparam logic [4:0] MUL_STEPS = 5'd4;
	localparam logic [4:0] MUL_LO    = 5'd4;
	localparam logic [4:0] MUL_HI    = 5'd3;
	localparam logic [4:0] MUL_ACC   = 5'd2;
	localparam logic [4:0] LAST_STEP = 5'd1;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        op_q;
	logic        neg_q;
	logic [32:0] a_q;
	logic [31:0] b_q;
	logic [31:0] rem_q;
	logic [30:0] dq_q;
	logic [48:0] pp_q;
	logic [63:0] acc_q;
	logic [31:0] res_q;

	logic [15:0] mul_b;
	logic [48:0] pp;
	logic [63:0] acc_sum;
	logic [47:0] prod_m;
	logic [31:0] mul_sat;
	logic [32:0] div_t;
	logic        div_ge;
	logic [31:0] rem_n;
	logic [30:0] dq_n;

	// One 33x16 multiplier serves both halves of the factor.
	always_comb begin
		mul_b   = (cnt_q == MUL_LO) ? b_q[15:0] : {1'b0, b_q[30:16]};
		pp      = 49'(a_q) * 49'(mul_b);
		acc_sum = acc_q + {pp_q[47:0], 16'b0};
		prod_m  = acc_q[63:16];
		if (neg_q) begin
			mul_sat = (prod_m >= 48'h8000_0000) ? 32'h8000_0000 : (~prod_m[31:0] + 32'd1);
		end else begin
			mul_sat = (prod_m >= 48'h8000_0000) ? 32'h7FFF_FFFF : prod_m[31:0];
		end
	end

	// Restoring divide, one quotient bit per step.
	always_comb begin
		div_t  = {rem_q, dq_q[30]};
		div_ge = div_t >= {1'b0, b_q};
		rem_n  = div_ge ? 32'(div_t - {1'b0, b_q}) : div_t[31:0];
		dq_n   = {dq_q[29:0], div_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_DIV) ? req.iters : MUL_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			neg_q <= req.neg;
			a_q   <= req.opa;
			b_q   <= req.opb;
			rem_q <= req.opa[31:0];
			dq_q  <= req.opc;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				rem_q <= rem_n;
				dq_q  <= dq_n;
				if (cnt_q == LAST_STEP) begin
					res_q <= {1'b0, dq_n};
				end
			end else begin
				unique case (cnt_q)
					MUL_LO: begin
						pp_q <= pp;
					end
					MUL_HI: begin
						acc_q <= {15'b0, pp_q};
						pp_q  <= pp;
					end
					MUL_ACC: begin
						acc_q <= acc_sum;
					end
					default: begin
						res_q <= mul_sat;
					end
				endcase
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ===== hdl/motor_speed_torque_controller.sv =====
// Motor speed and torque controller, one word per control tick.
// Input stream (s_*): one word carries the measured speed, the axis inertia,
// the target speed and the motor-on flag. The block ramps its commanded speed
// toward the target, forms the torque from the speed error, inertia and gain,
// adds a compensation term from the previous tick, clamps it and keeps the
// force, acceleration and speed for the next tick.
// Output stream (m_*): one word per input word, the Q16.16 torque in tdata and
// the result kind in tuser (0 when the commanded speed is zero).
// Configuration (APB): four 31-bit registers at byte addresses 0, 4, 8 and 12;
// the user must write them only while the block is idle, which the block itself
// does not enforce; reads return the register value.
// When the commanded speed is zero the word goes from the ramp step straight to
// the output register; otherwise the shared arithmetic unit sets its time, which
// grows with the quotient bits it divides (16 for the slowdown factor, 31 for
// the stored acceleration). One word is processed at a time and the next one is
// accepted only after the last has reached the output register.
// s_tready is high only while the sequencer is idle. A finished word waits in
// the output register while the next input is accepted; if the receiver still
// stalls when the next word finishes, the sequencer holds until the slot frees.
// Reset clears the ramp state and the stored tick history, sets the gain and
// damping to one and the clamp and ramp step to zero.
module motor_speed_torque_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] measured_speed, [62:32] axis_inertia, [94:63] target_speed, [95] motor_on
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] torque
	output logic [31:0] m_tdata,
	// [0] result_kind
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mstc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RAMP   = 4'd1;
	localparam logic [3:0] ST_ACC    = 4'd2;
	localparam logic [3:0] ST_MUL1   = 4'd3;
	localparam logic [3:0] ST_MUL2   = 4'd4;
	localparam logic [3:0] ST_DECIDE = 4'd5;
	localparam logic [3:0] ST_DIV1   = 4'd6;
	localparam logic [3:0] ST_MULF   = 4'd7;
	localparam logic [3:0] ST_MULT   = 4'd8;
	localparam logic [3:0] ST_CLAMP  = 4'd9;
	localparam logic [3:0] ST_PDIV   = 4'd10;
	localparam logic [3:0] ST_DIV2   = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sh0_7FFF_FFFF) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < -33'sh0_8000_0000) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// Multiply request: signed Q16.16 value times an unsigned Q16.16 factor.
	function automatic mstc_req_t mul_req(input logic signed [31:0] x, input logic [31:0] f);
		mstc_req_t r;
		r       = '0;
		r.start = 1'b1;
		r.op    = OP_MUL;
		r.neg   = x[31];
		r.opa   = mag33(33'(x));
		r.opb   = f;
		mul_req = r;
	endfunction

	// Configuration registers.
	logic [30:0] max_torque_q;
	logic [30:0] inertia_gain_q;
	logic [30:0] resist_damping_q;
	logic [30:0] ramp_step_q;

	// Tick history.
	logic signed [31:0] cmd_q;
	logic signed [31:0] pspeed_q;
	logic signed [31:0] paccel_q;
	logic signed [31:0] pforce_q;

	// Current word and working values.
	logic [3:0]         state_q;
	logic signed [31:0] meas_q;
	logic [30:0]        inert_q;
	logic signed [31:0] targ_q;
	logic               on_q;
	logic signed [32:0] accel_q;
	logic signed [32:0] d_q;
	logic signed [31:0] rot_q;
	logic               kind_q;
	mstc_req_t          req_q;
	mstc_rsp_t          rsp;

	logic        mvalid_q;
	logic [31:0] mdata_q;
	logic        muser_q;

	logic               cfg_we;
	logic signed [32:0] delta;
	logic signed [32:0] step;
	logic signed [31:0] cmd_n;
	logic signed [32:0] accel_n;
	logic [32:0]        mag_d;
	logic [31:0]        mag_pa;
	logic [31:0]        mag_r;
	logic               same_sign;
	logic               small_d;
	logic signed [31:0] lim;
	logic [16:0]        slow_f;
	logic [30:0]        acc_q31;

	mstc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_TORQUE:     prdata = {1'b0, max_torque_q};
			REG_INERTIA_GAIN:   prdata = {1'b0, inertia_gain_q};
			REG_RESIST_DAMPING: prdata = {1'b0, resist_damping_q};
			REG_RAMP_STEP:      prdata = {1'b0, ramp_step_q};
		endcase
	end

	always_comb begin
		// Ramp toward the target; with the motor on the result lies between old and target, else it is zero.
		delta = 33'(targ_q) - 33'(cmd_q);
		step  = $signed({2'b0, ramp_step_q});
		if (!on_q) begin
			cmd_n = '0;
		end else if (delta > step) begin
			cmd_n = 32'(33'(cmd_q) + step);
		end else if (delta < -step) begin
			cmd_n = 32'(33'(cmd_q) - step);
		end else begin
			cmd_n = targ_q;
		end
		accel_n = 33'(cmd_q) - 33'(meas_q);

		mag_d     = mag33(d_q);
		mag_pa    = 32'(mag33(33'(paccel_q)));
		mag_r     = 32'(mag33(33'(rot_q)));
		same_sign = (d_q != 0) && (accel_q != 0) && (d_q[32] == accel_q[32]);
		// |d| * 20 < |prev_accel|, exact.
		small_d   = (({5'b0, mag_d} << 4) + ({5'b0, mag_d} << 2)) < 38'(mag_pa);
		lim       = $signed({1'b0, max_torque_q});
		slow_f    = Q_ONE - {1'b0, rsp.result[15:0]};
		acc_q31   = rsp.result[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_torque_q     <= '0;
			inertia_gain_q   <= 31'(Q_ONE);
			resist_damping_q <= 31'(Q_ONE);
			ramp_step_q      <= '0;
			cmd_q            <= '0;
			pspeed_q         <= '0;
			paccel_q         <= '0;
			pforce_q         <= '0;
			state_q          <= ST_IDLE;
			req_q            <= '0;
			mvalid_q         <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (paddr[3:2])
					REG_MAX_TORQUE:     max_torque_q     <= pwdata[30:0];
					REG_INERTIA_GAIN:   inertia_gain_q   <= pwdata[30:0];
					REG_RESIST_DAMPING: resist_damping_q <= pwdata[30:0];
					REG_RAMP_STEP:      ramp_step_q      <= pwdata[30:0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						meas_q  <= $signed(s_tdata[31:0]);
						inert_q <= s_tdata[62:32];
						targ_q  <= $signed(s_tdata[94:63]);
						on_q    <= s_tdata[95];
						state_q <= ST_RAMP;
					end
				end
				ST_RAMP: begin
					cmd_q <= cmd_n;
					if (cmd_n == 0) begin
						// Nothing applied; the tick history stays as it is.
						rot_q   <= '0;
						kind_q  <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						kind_q  <= 1'b1;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					accel_q      <= accel_n;
					d_q          <= 33'(meas_q) - 33'(pspeed_q);
					req_q        <= '0;
					req_q.start  <= 1'b1;
					req_q.op     <= OP_MUL;
					req_q.neg    <= accel_n[32];
					req_q.opa    <= mag33(accel_n);
					req_q.opb    <= {1'b0, inert_q};
					state_q      <= ST_MUL1;
				end
				ST_MUL1: begin
					if (rsp.done) begin
						req_q   <= mul_req($signed(rsp.result), {1'b0, inertia_gain_q});
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (rsp.done) begin
						rot_q   <= $signed(rsp.result);
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (paccel_q == 0) begin
						state_q <= ST_CLAMP;
					end else if (same_sign) begin
						if (d_q[32] != paccel_q[31]) begin
							// Negative ratio: the slowdown factor is one.
							req_q   <= mul_req(pforce_q, 32'(Q_ONE));
							state_q <= ST_MULF;
						end else if (mag_d >= {1'b0, mag_pa}) begin
							// Ratio of one or more: the term vanishes.
							state_q <= ST_CLAMP;
						end else begin
							req_q       <= '0;
							req_q.start <= 1'b1;
							req_q.op    <= OP_DIV;
							req_q.opa   <= mag_d;
							req_q.opb   <= mag_pa;
							req_q.opc   <= '0;
							req_q.iters <= DIV_F_BITS;
							state_q     <= ST_DIV1;
						end
					end else if ((meas_q != 0) && small_d) begin
						req_q   <= mul_req(pforce_q, {1'b0, resist_damping_q});
						state_q <= ST_MULT;
					end else begin
						state_q <= ST_CLAMP;
					end
				end
				ST_DIV1: begin
					if (rsp.done) begin
						req_q   <= mul_req(pforce_q, 32'(slow_f));
						state_q <= ST_MULF;
					end
				end
				ST_MULF: begin
					if (rsp.done) begin
						req_q   <= mul_req($signed(rsp.result), {1'b0, resist_damping_q});
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (rsp.done) begin
						rot_q   <= sat32(33'(rot_q) + 33'($signed(rsp.result)));
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (max_torque_q != 0) begin
						if (rot_q > lim) begin
							rot_q <= lim;
						end else if (rot_q < -lim) begin
							rot_q <= -lim;
						end
					end
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					pforce_q <= rot_q;
					pspeed_q <= meas_q;
					priority if (inert_q == 0) begin
						paccel_q <= '0;
						state_q  <= ST_OUT;
					end else if (46'(mag_r) >= {inert_q, 15'b0}) begin
						// The quotient reaches 2^31 and saturates.
						paccel_q <= rot_q[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
						state_q  <= ST_OUT;
					end else begin
						req_q       <= '0;
						req_q.start <= 1'b1;
						req_q.op    <= OP_DIV;
						req_q.opa   <= {16'b0, mag_r[31:15]};
						req_q.opb   <= {1'b0, inert_q};
						req_q.opc   <= {mag_r[14:0], 16'b0};
						req_q.iters <= DIV_A_BITS;
						state_q     <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (rsp.done) begin
						paccel_q <= rot_q[31] ? -$signed({1'b0, acc_q31})
						                      : $signed({1'b0, acc_q31});
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!mvalid_q || m_tready) begin
						mvalid_q <= 1'b1;
						mdata_q  <= rot_q;
						muser_q  <= kind_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

`ifndef SYNTHESIS
	// The shared unit only finishes while the sequencer waits for it.
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_DIV1 ||
		              state_q == ST_MULF || state_q == ST_MULT || state_q == ST_DIV2))
		else $error("shared unit finished outside a wait state");

	a_accept_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_RAMP))
		else $error("accepted word did not start the ramp");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
		else $error("nothing-applied word carries torque");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && (max_torque_q != 0)) |->
		($signed(m_tdata) <= lim && $signed(m_tdata) >= -lim))
		else $error("torque exceeds the clamp");
`endif

endmodule
